FILE: rtl/timed_travel_position_tracker_defines.svh
// ----------------------------------------------------------------------------
// timed travel position tracker assertion macros
// shared concurrent assertion forms, clocked on clk and masked during rst
// ----------------------------------------------------------------------------
`ifndef TIMED_TRAVEL_POSITION_TRACKER_DEFINES_SVH
`define TIMED_TRAVEL_POSITION_TRACKER_DEFINES_SVH

// same-cycle implication
`define TTPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TTPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ttpt_pkg.sv
// ----------------------------------------------------------------------------
// ttpt_pkg
// types, constants and register codes of the timed travel position tracker
// ----------------------------------------------------------------------------
`default_nettype none

package ttpt_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] cover_request;
  } in_item_t;

  typedef struct packed {
    logic        motor_running;
    logic        moving_up;
    logic [15:0] position_now;
    logic [15:0] target_now;
    logic [6:0]  cover_now;
  } out_item_t;

  typedef struct packed {
    logic [15:0] top_position;
    logic [15:0] bottom_position;
    logic [15:0] top_overtravel_limit;
    logic [15:0] bottom_overtravel_limit;
  } cfg_t;

  // transaction between the target pipeline and the state stage
  typedef struct packed {
    logic        cmd;
    logic [7:0]  cover_request;
    logic [16:0] quot;
  } tgt_item_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TOP_POS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_POS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_LIM    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_LIM = 2'd3;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  localparam logic [15:0] RST_TOP_POS    = 16'd500;
  localparam logic [15:0] RST_BOTTOM_POS = 16'd4650;
  localparam logic [15:0] RST_TOP_LIM    = 16'd200;
  localparam logic [15:0] RST_BOTTOM_LIM = 16'd4950;

  localparam logic [6:0] PERCENT_MAX = 7'd100;

  // product bias of 100 * 2^16 keeps the signed product non-negative;
  // the 2^16 it adds to the quotient vanishes in the 16-bit target sum
  localparam logic [23:0] PROD_BIAS    = 24'd6553600;
  // ceil(2^31 / 100), exact floor division for values below 2^24
  localparam logic [24:0] RECIP_100    = 25'd21474837;
  localparam int unsigned RECIP_SHIFT  = 31;

endpackage

`default_nettype wire

FILE: rtl/timed_travel_position_tracker.sv
// path: input, product and quotient registers of the target, then the state register
// throughput: one transaction per cycle while no held, untaken result stalls it; the multiplies of the
//   target pipeline are staged so only the state update closes on itself
// reset (synchronous, active high): registers return to their defaults, pipeline
//   empties, motor state starts a calibration run upward from the bottom position
// ----------------------------------------------------------------------------
// timed_travel_position_tracker
// dead-reckoning position tracker for a motor-driven blind with config registers
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_travel_position_tracker_defines.svh"

module timed_travel_position_tracker (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  ttpt_pkg::in_item_t                    in_item,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output ttpt_pkg::out_item_t                   out_item,
  input  wire                                   cfg_we,
  input  wire  [ttpt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [ttpt_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import ttpt_pkg::*;

  cfg_t      cfg;
  logic      tgt_valid;
  logic      tgt_ready;
  tgt_item_t tgt_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.top_position            <= RST_TOP_POS;
      cfg.bottom_position         <= RST_BOTTOM_POS;
      cfg.top_overtravel_limit    <= RST_TOP_LIM;
      cfg.bottom_overtravel_limit <= RST_BOTTOM_LIM;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOP_POS:    cfg.top_position            <= cfg_wdata;
        CFG_BOTTOM_POS: cfg.bottom_position         <= cfg_wdata;
        CFG_TOP_LIM:    cfg.top_overtravel_limit    <= cfg_wdata;
        CFG_BOTTOM_LIM: cfg.bottom_overtravel_limit <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ttpt_target u_target (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cfg       (cfg),
    .out_valid (tgt_valid),
    .out_ready (tgt_ready),
    .out_item  (tgt_item)
  );

  ttpt_state u_state (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tgt_valid),
    .in_ready  (tgt_ready),
    .in_item   (tgt_item),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // input can only stall behind a held, untaken result
  `TTPT_ASSERT_SAME(a_stall_cause, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")
  // with no result held every stage can advance
  `TTPT_ASSERT_SAME(a_free_ready, !out_valid, in_ready, "input not ready while output empty")
  // stored percent never leaves its range
  `TTPT_ASSERT_SAME(a_cover_range, 1'b1, out_item.cover_now <= PERCENT_MAX, "cover percent out of range")
  // a held result stays valid until it is taken
  `TTPT_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

`default_nettype wire

FILE: rtl/ttpt_target.sv
// ----------------------------------------------------------------------------
// ttpt_target
// three-stage pipeline: input register, percent times span, floor divide by 100
// ----------------------------------------------------------------------------
`default_nettype none

module ttpt_target (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  ttpt_pkg::in_item_t   in_item,
  input  ttpt_pkg::cfg_t       cfg,
  output logic                 out_valid,
  input  wire                  out_ready,
  output ttpt_pkg::tgt_item_t  out_item
);
  import ttpt_pkg::*;

  logic               v1;
  in_item_t           item1;
  logic               v2;
  logic               cmd2;
  logic [7:0]         req2;
  logic [23:0]        prod2;
  logic               v3;
  tgt_item_t          item3;
  logic               rdy1;
  logic               rdy2;
  logic               rdy3;
  logic signed [16:0] span;
  logic signed [24:0] prod_full;
  logic [23:0]        biased;
  logic [48:0]        qprod;

  assign rdy3 = !v3 || out_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  assign span      = $signed({1'b0, cfg.bottom_position}) - $signed({1'b0, cfg.top_position});
  assign prod_full = $signed({1'b0, item1.cover_request[6:0]}) * span;
  assign biased    = prod2 + PROD_BIAS;
  assign qprod     = {25'd0, biased} * {24'd0, RECIP_100};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      item1 <= in_item;
    end
    if (rdy2) begin
      cmd2  <= item1.cmd;
      req2  <= item1.cover_request;
      prod2 <= prod_full[23:0];
    end
    if (rdy3) begin
      item3.cmd           <= cmd2;
      item3.cover_request <= req2;
      item3.quot          <= qprod[RECIP_SHIFT+16:RECIP_SHIFT];
    end
  end

  assign out_valid = v3;
  assign out_item  = item3;

endmodule

`default_nettype wire

FILE: rtl/ttpt_state.sv
// ----------------------------------------------------------------------------
// ttpt_state
// position, target and motor state update; the state doubles as result register
// ----------------------------------------------------------------------------
`default_nettype none

module ttpt_state (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  ttpt_pkg::tgt_item_t  in_item,
  input  ttpt_pkg::cfg_t       cfg,
  output logic                 out_valid,
  input  wire                  out_ready,
  output ttpt_pkg::out_item_t  out_item
);
  import ttpt_pkg::*;

  logic        ovalid;
  logic [15:0] position;
  logic [15:0] target;
  logic        heading_up;
  logic        running;
  logic [6:0]  cover_percent;

  logic [15:0] position_next;
  logic [15:0] target_next;
  logic        heading_up_next;
  logic        running_next;
  logic [6:0]  cover_percent_next;

  logic        fire;
  logic [15:0] pos_dec;
  logic [15:0] pos_inc;
  logic [15:0] tgt_calc;
  logic        req_take;

  assign in_ready = !ovalid || out_ready;
  assign fire     = in_valid && in_ready;

  assign pos_dec  = position - 16'd1;
  assign pos_inc  = position + 16'd1;
  assign req_take = (in_item.cover_request <= {1'b0, PERCENT_MAX})
                 && (in_item.cover_request != {1'b0, cover_percent});

  always_comb begin
    if (in_item.cover_request[6:0] == 7'd0) begin
      tgt_calc = cfg.top_overtravel_limit;
    end else if (in_item.cover_request[6:0] == PERCENT_MAX) begin
      tgt_calc = cfg.bottom_overtravel_limit;
    end else begin
      tgt_calc = cfg.top_position + in_item.quot[15:0];
    end
  end

  always_comb begin
    position_next      = position;
    target_next        = target;
    heading_up_next    = heading_up;
    running_next       = running;
    cover_percent_next = cover_percent;
    case (in_item.cmd)
      CMD_TICK: begin
        if (running) begin
          if (heading_up) begin
            position_next = pos_dec;
            if (pos_dec <= target || pos_dec < cfg.top_overtravel_limit) begin
              running_next = 1'b0;
              // top overtravel re-zero
              if (pos_dec <= cfg.top_overtravel_limit) begin
                position_next = cfg.top_position;
              end
            end
          end else begin
            position_next = pos_inc;
            if (pos_inc >= target || pos_inc > cfg.bottom_overtravel_limit) begin
              running_next = 1'b0;
              if (pos_inc >= cfg.bottom_overtravel_limit) begin
                position_next = cfg.bottom_position;
              end
            end
          end
        end
      end
      CMD_SET: begin
        if (req_take) begin
          cover_percent_next = in_item.cover_request[6:0];
          target_next        = tgt_calc;
          if (tgt_calc != position) begin
            heading_up_next = tgt_calc < position;
            running_next    = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid        <= 1'b0;
      position      <= RST_BOTTOM_POS;
      target        <= RST_TOP_LIM;
      heading_up    <= 1'b1;
      running       <= 1'b1;
      cover_percent <= 7'd0;
    end else begin
      if (in_ready) begin
        ovalid <= in_valid;
      end
      if (fire) begin
        position      <= position_next;
        target        <= target_next;
        heading_up    <= heading_up_next;
        running       <= running_next;
        cover_percent <= cover_percent_next;
      end
    end
  end

  assign out_valid              = ovalid;
  assign out_item.motor_running = running;
  assign out_item.moving_up     = heading_up;
  assign out_item.position_now  = position;
  assign out_item.target_now    = target;
  assign out_item.cover_now     = cover_percent;

endmodule

`default_nettype wire
